/* rtl/lirc_pkg.sv */
// Shared types and codes for the row cache core.
// Used by lru_indexed_row_cache_core; no dependencies of its own.
package lirc_pkg;

    localparam int INDEX_W = 32;
    localparam int STAMP_W = 64;
    localparam int SIZE_W  = 33;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam logic CFG_SOURCE_SIZE    = 1'b0;
    localparam logic CFG_LOADER_ENABLED = 1'b1;

    typedef enum logic [2:0] {
        STATUS_HIT         = 3'd0,
        STATUS_FILLED      = 3'd1,
        STATUS_LOAD_FAILED = 3'd2,
        STATUS_REJECTED    = 3'd3,
        STATUS_CLEARED     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_LOOKUP,
        KIND_REJECT,
        KIND_CLEAR
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

/* rtl/lirc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module lirc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lru_indexed_row_cache_core.sv */
// Fully associative row cache with least-recently-used replacement.
// Depends on lirc_pkg and lirc_ram.
//
// Usage: a request (i_req_*) is a lookup of a row index or a clear of the
// whole cache. Each request yields exactly one response (o_rsp_*) carrying
// a status, the row payload and an eviction flag. Both channels use
// valid/ready; the configuration channel (i_cfg_*) writes source_size
// (index 0) or loader_enabled (index 1) and is always ready.
// A lookup that passes the range and loader checks walks the slot memory one slot
// per cycle through its single read port, then registers its response. Rejected
// lookups and clears skip the scan. One request is in flight at a time; the next
// request is accepted in the cycle after the previous one reaches the output
// register.
// When the receiver stalls, the response is held in the output register and
// the next request runs its scan, then waits until the register is free.
// Reset empties the cache, zeroes the use counter and the configuration.
// Slot contents live in memory; only the per-slot valid bits are flops.
module lru_indexed_row_cache_core #(
    parameter int ENTRIES    = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic                        i_req_type,
    input  logic [lirc_pkg::INDEX_W-1:0] i_index,
    input  logic                        i_fill_valid,
    input  logic [31:0]                 i_fill_data,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic [2:0]                  o_status,
    output logic [31:0]                 o_row_data,
    output logic                        o_evicted,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [lirc_pkg::SIZE_W-1:0] i_cfg_data
);

    import lirc_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = INDEX_W + DATA_WIDTH + STAMP_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    t_state                r_state;
    t_state                n_state;
    t_req_kind             r_kind;
    logic [ADDR_W-1:0]     r_cmp_addr;
    logic [ADDR_W-1:0]     n_cmp_addr;
    logic [INDEX_W-1:0]    r_req_index;
    logic                  r_fill_valid;
    logic [DATA_WIDTH-1:0] r_fill_data;

    logic                  r_hit;
    logic [ADDR_W-1:0]     r_hit_slot;
    logic [DATA_WIDTH-1:0] r_hit_data;
    logic                  r_have_victim;
    logic [ADDR_W-1:0]     r_victim_slot;
    logic [STAMP_W-1:0]    r_victim_stamp;
    logic                  r_have_free;
    logic [ADDR_W-1:0]     r_free_slot;

    logic [ENTRIES-1:0]    r_valid;
    logic [STAMP_W-1:0]    r_use_counter;
    logic [STAMP_W-1:0]    n_use_counter;
    logic [SIZE_W-1:0]     r_source_size;
    logic                  r_loader_enabled;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [31:0]           r_out_row_data;
    logic                  r_out_evicted;

    logic                  req_fire;
    logic                  finish_fire;
    logic                  req_rejected;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;

    logic [INDEX_W-1:0]    ent_index;
    logic [DATA_WIDTH-1:0] ent_data;
    logic [STAMP_W-1:0]    ent_stamp;
    logic                  ent_valid;

    logic [DATA_WIDTH+31:0] fill_ext;
    logic [DATA_WIDTH+31:0] hit_ext;
    logic [DATA_WIDTH+31:0] new_ext;
    logic [ADDR_W-1:0]      fill_slot;

    lirc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent_index = ram_rdata[INDEX_W-1:0];
    assign ent_data  = ram_rdata[INDEX_W +: DATA_WIDTH];
    assign ent_stamp = ram_rdata[INDEX_W+DATA_WIDTH +: STAMP_W];
    assign ent_valid = r_valid[r_cmp_addr];

    assign req_fire     = i_req_valid && o_req_ready;
    assign req_rejected = ({1'b0, i_index} >= r_source_size) || !r_loader_enabled;
    assign finish_fire  = (r_state == ST_FINISH) && (!r_out_valid || i_rsp_ready);
    assign fill_slot    = r_have_free ? r_free_slot : r_victim_slot;
    assign n_use_counter = r_use_counter + STAMP_W'(1);

    assign fill_ext = {{DATA_WIDTH{1'b0}}, i_fill_data};
    assign hit_ext  = {32'd0, r_hit_data};
    assign new_ext  = {32'd0, r_fill_data};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (i_req_type == REQ_CLEAR || req_rejected) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cmp_addr == LAST_ADDR) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (finish_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        n_cmp_addr  = r_cmp_addr;
        ram_we      = 1'b0;
        ram_waddr   = fill_slot;
        ram_wdata   = {n_use_counter, r_fill_data, r_req_index};
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                ram_re      = 1'b1;
                n_cmp_addr  = '0;
            end
            ST_SCAN: begin
                ram_re     = 1'b1;
                ram_raddr  = r_cmp_addr + ADDR_W'(1);
                n_cmp_addr = r_cmp_addr + ADDR_W'(1);
            end
            ST_FINISH: begin
                if (r_hit) begin
                    ram_waddr = r_hit_slot;
                    ram_wdata = {n_use_counter, r_hit_data, r_req_index};
                end
                ram_we = finish_fire && (r_kind == KIND_LOOKUP) && (r_hit || r_fill_valid);
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_cmp_addr       <= '0;
            r_kind           <= KIND_LOOKUP;
            r_hit            <= 1'b0;
            r_have_victim    <= 1'b0;
            r_have_free      <= 1'b0;
            r_valid          <= '0;
            r_use_counter    <= '0;
            r_source_size    <= '0;
            r_loader_enabled <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_addr <= n_cmp_addr;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SOURCE_SIZE:    r_source_size    <= i_cfg_data;
                    CFG_LOADER_ENABLED: r_loader_enabled <= i_cfg_data[0];
                    default:            r_loader_enabled <= r_loader_enabled;
                endcase
            end

            if (req_fire) begin
                r_hit         <= 1'b0;
                r_have_victim <= 1'b0;
                r_have_free   <= 1'b0;
                if (i_req_type == REQ_CLEAR) begin
                    r_kind <= KIND_CLEAR;
                end else if (req_rejected) begin
                    r_kind <= KIND_REJECT;
                end else begin
                    r_kind <= KIND_LOOKUP;
                end
            end

            if (r_state == ST_SCAN) begin
                if (ent_valid && !r_hit && ent_index == r_req_index) begin
                    r_hit <= 1'b1;
                end
                if (ent_valid && (!r_have_victim || ent_stamp < r_victim_stamp)) begin
                    r_have_victim <= 1'b1;
                end
                if (!ent_valid && !r_have_free) begin
                    r_have_free <= 1'b1;
                end
            end

            if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end

            if (finish_fire) begin
                r_out_valid <= 1'b1;
                case (r_kind)
                    KIND_CLEAR: begin
                        r_valid       <= '0;
                        r_use_counter <= '0;
                    end
                    KIND_LOOKUP: begin
                        if (r_hit) begin
                            r_use_counter <= n_use_counter;
                        end else if (r_fill_valid) begin
                            r_use_counter        <= n_use_counter;
                            r_valid[fill_slot]   <= 1'b1;
                        end
                    end
                    default: begin
                        r_use_counter <= r_use_counter;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req_index  <= i_index;
            r_fill_valid <= i_fill_valid;
            r_fill_data  <= fill_ext[DATA_WIDTH-1:0];
        end

        if (r_state == ST_SCAN) begin
            if (ent_valid && !r_hit && ent_index == r_req_index) begin
                r_hit_slot <= r_cmp_addr;
                r_hit_data <= ent_data;
            end
            if (ent_valid && (!r_have_victim || ent_stamp < r_victim_stamp)) begin
                r_victim_slot  <= r_cmp_addr;
                r_victim_stamp <= ent_stamp;
            end
            if (!ent_valid && !r_have_free) begin
                r_free_slot <= r_cmp_addr;
            end
        end

        if (finish_fire) begin
            r_out_row_data <= '0;
            r_out_evicted  <= 1'b0;
            case (r_kind)
                KIND_CLEAR: begin
                    r_out_status <= STATUS_CLEARED;
                end
                KIND_REJECT: begin
                    r_out_status <= STATUS_REJECTED;
                end
                KIND_LOOKUP: begin
                    if (r_hit) begin
                        r_out_status   <= STATUS_HIT;
                        r_out_row_data <= hit_ext[31:0];
                    end else if (r_fill_valid) begin
                        r_out_status   <= STATUS_FILLED;
                        r_out_row_data <= new_ext[31:0];
                        r_out_evicted  <= !r_have_free;
                    end else begin
                        r_out_status <= STATUS_LOAD_FAILED;
                    end
                end
                default: begin
                    r_out_status <= STATUS_REJECTED;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_row_data  = r_out_row_data;
    assign o_evicted   = r_out_evicted;
    assign o_cfg_ready = 1'b1;

    a_evict_only_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_evicted |-> o_status == STATUS_FILLED)
        else $error("eviction flagged on a response that is not a fill");

    a_quiet_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_status != STATUS_HIT && o_status != STATUS_FILLED
        |-> o_row_data == 32'd0 && !o_evicted)
        else $error("payload or eviction set on a non-data response");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_fire && r_kind == KIND_CLEAR |=> r_valid == '0 && r_use_counter == '0)
        else $error("clear left valid slots or a nonzero use counter");

    a_slot_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && r_kind == KIND_LOOKUP |-> r_have_free || r_have_victim)
        else $error("scan finished with neither a free slot nor a victim");

endmodule

/* dv/lirc_row_checker.sv */
// Checker for the row cache core: mirrors the cache contents and configuration,
// predicts one response per accepted request and compares responses in order.
// Depends on lirc_pkg for the status, request and register codes.
`timescale 1ns / 1ps

module lirc_row_checker #(
    parameter int ENTRIES    = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic                         i_req_type,
    input  logic [lirc_pkg::INDEX_W-1:0] i_index,
    input  logic                         i_fill_valid,
    input  logic [31:0]                  i_fill_data,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic [2:0]                   i_status,
    input  logic [31:0]                  i_row_data,
    input  logic                         i_evicted,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [lirc_pkg::SIZE_W-1:0]  i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import lirc_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] row_data;
        logic        evicted;
    } t_row_rsp;

    logic              slot_used  [ENTRIES];
    logic [31:0]       slot_row   [ENTRIES];
    logic [63:0]       slot_payload [ENTRIES];
    logic [63:0]       slot_age   [ENTRIES];
    logic [63:0]       use_seq;
    logic [SIZE_W-1:0] size_cfg;
    logic              loader_cfg;

    t_row_rsp owed_rows[$];
    t_row_rsp want;
    t_row_rsp got;
    int       fails;

    initial begin
        fails = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic void clear_cache();
        for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 1'b0;
        end
        use_seq = '0;
    endfunction

    function automatic t_row_rsp predict_row(logic rtype, logic [31:0] idx, logic fv,
                                             logic [31:0] fd);
        t_row_rsp    r;
        int          victim;
        int          free_slot;
        int          used;
        logic [63:0] mask;
        r.status   = STATUS_HIT;
        r.row_data = '0;
        r.evicted  = 1'b0;
        victim     = -1;
        free_slot  = -1;
        used       = 0;
        mask       = (DATA_WIDTH >= 64) ? '1 : ((64'd1 << DATA_WIDTH) - 64'd1);
        if (rtype == REQ_CLEAR) begin
            clear_cache();
            r.status = STATUS_CLEARED;
            return r;
        end
        if ({1'b0, idx} >= size_cfg || !loader_cfg) begin
            r.status = STATUS_REJECTED;
            return r;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_row[i] == idx) begin
                use_seq     = use_seq + 64'd1;
                slot_age[i] = use_seq;
                r.row_data  = slot_payload[i][31:0];
                return r;
            end
        end
        if (!fv) begin
            r.status = STATUS_LOAD_FAILED;
            return r;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
                used++;
                if (victim < 0 || slot_age[i] < slot_age[victim]) begin
                    victim = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (used >= ENTRIES || free_slot < 0) begin
            free_slot = victim;
            r.evicted = 1'b1;
        end
        if (free_slot < 0) begin
            free_slot = 0;
        end
        use_seq                 = use_seq + 64'd1;
        slot_used[free_slot]    = 1'b1;
        slot_row[free_slot]     = idx;
        slot_payload[free_slot] = {32'd0, fd} & mask;
        slot_age[free_slot]     = use_seq;
        r.status   = STATUS_FILLED;
        r.row_data = slot_payload[free_slot][31:0];
        return r;
    endfunction

    task automatic report_bad(string why, t_row_rsp exp_rsp, t_row_rsp act_rsp);
        if (fails < 10) begin
            $display("%s: status exp %0d got %0d, row_data exp %h got %h, evicted exp %b got %b",
                     why, exp_rsp.status, act_rsp.status, exp_rsp.row_data, act_rsp.row_data,
                     exp_rsp.evicted, act_rsp.evicted);
        end
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_cache();
            size_cfg   = '0;
            loader_cfg = 1'b0;
            owed_rows.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SOURCE_SIZE) begin
                    size_cfg = i_cfg_data;
                end else begin
                    loader_cfg = i_cfg_data[0];
                end
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got.status   = t_status'(i_status);
                got.row_data = i_row_data;
                got.evicted  = i_evicted;
                if (owed_rows.size() == 0) begin
                    want.status   = STATUS_HIT;
                    want.row_data = '0;
                    want.evicted  = 1'b0;
                    report_bad("response with no request outstanding", want, got);
                end else begin
                    want = owed_rows.pop_front();
                    if (want.status !== i_status || want.row_data !== i_row_data ||
                        want.evicted !== i_evicted) begin
                        report_bad("response mismatch", want, got);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                owed_rows.push_back(predict_row(i_req_type, i_index, i_fill_valid,
                                                i_fill_data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_rows.size();
    end

endmodule

/* dv/tb_top.sv */
// Top of the row cache testbench: clock, reset, request and register stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on lirc_pkg, lru_indexed_row_cache_core and lirc_row_checker.
`timescale 1ns / 1ps

module tb_top;
    import lirc_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int DATA_WIDTH    = 32;
    localparam int SETTLE_CYCLES = 2 * (ENTRIES + 4);
    localparam int QUIET_LIMIT   = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_req_valid;
    logic               o_req_ready;
    logic               i_req_type;
    logic [INDEX_W-1:0] i_index;
    logic               i_fill_valid;
    logic [31:0]        i_fill_data;
    logic               o_rsp_valid;
    logic               i_rsp_ready;
    logic [2:0]         o_status;
    logic [31:0]        o_row_data;
    logic               o_evicted;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [SIZE_W-1:0]  i_cfg_data;

    int fail_total;
    int rsp_owed;
    int send_idle_pct;
    int rsp_stall_pct;
    int quiet_cycles;

    lru_indexed_row_cache_core #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_fill_valid (i_fill_valid),
        .i_fill_data  (i_fill_data),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_status     (o_status),
        .o_row_data   (o_row_data),
        .o_evicted    (o_evicted),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    lirc_row_checker #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_row_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_fill_valid (i_fill_valid),
        .i_fill_data  (i_fill_data),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_status     (o_status),
        .i_row_data   (o_row_data),
        .i_evicted    (o_evicted),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_total),
        .o_pending    (rsp_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_req_valid   = 1'b0;
        i_req_type    = REQ_LOOKUP;
        i_index       = '0;
        i_fill_valid  = 1'b0;
        i_fill_data   = '0;
        i_rsp_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SOURCE_SIZE;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        quiet_cycles  = 0;
    end

    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_row_req(logic rtype, logic [31:0] idx, logic fv, logic [31:0] fd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid  <= 1'b1;
        i_req_type   <= rtype;
        i_index      <= idx;
        i_fill_valid <= fv;
        i_fill_data  <= fd;
        @(posedge i_clk);
        while (!o_req_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_owed != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic ridx, logic [SIZE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int count, logic [31:0] base, int span);
        int          k;
        int          roll;
        logic [31:0] idx;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_row_req(REQ_CLEAR, $urandom(), 1'($urandom_range(1)), $urandom());
            end else begin
                if (roll < 18) begin
                    idx = $urandom();
                end else begin
                    idx = base + 32'($urandom_range(span - 1));
                end
                send_row_req(REQ_LOOKUP, idx, ($urandom_range(99) < 85), $urandom());
            end
        end
    endtask

    initial begin
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_row_req(REQ_LOOKUP, 32'd0, 1'b1, 32'h1234_5678);
        send_row_req(REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        settle();
        write_reg(CFG_SOURCE_SIZE, 33'd5);
        send_row_req(REQ_LOOKUP, 32'd1, 1'b1, 32'h0000_0001);
        settle();
        write_reg(CFG_LOADER_ENABLED, 33'd1);
        write_reg(CFG_SOURCE_SIZE, 33'h1_0000_0000);
        send_row_req(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'hAAAA_AAAA);
        send_row_req(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_row_req(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
        for (k = 0; k < ENTRIES - 1; k++) begin
            send_row_req(REQ_LOOKUP, 32'(k), 1'b1, 32'h0000_0100 + 32'(k));
        end
        send_row_req(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
        send_row_req(REQ_LOOKUP, 32'h8000_0000, 1'b1, 32'h0000_0000);
        send_row_req(REQ_LOOKUP, 32'd0, 1'b1, 32'h5555_5555);
        send_row_req(REQ_CLEAR, 32'd0, 1'b0, 32'd0);
        settle();
        write_reg(CFG_SOURCE_SIZE, 33'd100);
        send_row_req(REQ_LOOKUP, 32'd99, 1'b1, 32'hDEAD_BEEF);
        send_row_req(REQ_LOOKUP, 32'd100, 1'b1, 32'hBEEF_DEAD);

        settle();
        write_reg(CFG_SOURCE_SIZE, 33'h1_0000_0000);
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        run_random(140, 32'hFFFF_FFE8, 24);

        settle();
        write_reg(CFG_SOURCE_SIZE, 33'd20);
        send_idle_pct = 84;
        rsp_stall_pct = 0;
        run_random(110, 32'd0, 24);

        settle();
        write_reg(CFG_SOURCE_SIZE, {1'($urandom_range(1)), 32'($urandom())});
        send_idle_pct = 0;
        rsp_stall_pct = 84;
        run_random(140, 32'd0, 24);

        settle();
        write_reg(CFG_SOURCE_SIZE, 33'h0_FFFF_FFFF);
        send_idle_pct = 13;
        rsp_stall_pct = 13;
        run_random(140, 32'h7FFF_FFF4, 24);

        settle();
        write_reg(CFG_SOURCE_SIZE, 33'd0);
        run_random(20, 32'd0, 24);
        settle();
        write_reg(CFG_LOADER_ENABLED, 33'd0);
        write_reg(CFG_SOURCE_SIZE, 33'h1_0000_0000);
        run_random(20, 32'd0, 24);

        settle();
        write_reg(CFG_LOADER_ENABLED, 33'd1);
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        run_random(30, 32'd0, 24);

        settle();
        if (fail_total == 0 && rsp_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/lirc_pkg.sv
rtl/lirc_ram.sv
rtl/lru_indexed_row_cache_core.sv
dv/lirc_row_checker.sv
dv/tb_top.sv
